// ----- hdl/ising_metropolis_flip_assert.svh -----
`ifndef ISING_METROPOLIS_FLIP_ASSERT_SVH
`define ISING_METROPOLIS_FLIP_ASSERT_SVH

// same-cycle implication, checked on clk, off during rst
`define IMF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("imf assertion failed");

// next-cycle implication, checked on clk, off during rst
`define IMF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("imf assertion failed");

`endif

// ----- hdl/imf_pkg.sv -----
package imf_pkg;

  typedef logic signed [39:0] energy_t;
  typedef logic signed [13:0] moment_t;
  typedef logic [16:0]        thresh_t;

  localparam logic [2:0] CMD_STEP  = 3'd0;
  localparam logic [2:0] CMD_WSPIN = 3'd1;
  localparam logic [2:0] CMD_WTHR  = 3'd2;
  localparam logic [2:0] CMD_ELOAD = 3'd3;
  localparam logic [2:0] CMD_MLOAD = 3'd4;

  localparam logic [1:0] CFG_SIDE = 2'd0;
  localparam logic [1:0] CFG_J    = 2'd1;
  localparam logic [1:0] CFG_B    = 2'd2;

  localparam int NUM_THRESH = 10;

  localparam energy_t E_MAX = {1'b0, {39{1'b1}}};
  localparam energy_t E_MIN = {1'b1, {39{1'b0}}};
  localparam thresh_t THR_ONE = 17'h10000;

endpackage

// ----- hdl/imf_ram.sv -----
module imf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wen,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     ren,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    if (ren) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/ising_metropolis_flip.sv -----
// Metropolis single-site update of a periodic 2D Ising lattice. Commands are
// taken on start while busy is low; every command gives one result on done,
// shown for exactly one cycle with flipped, energy and moment; the receiver
// cannot hold it off. A step or a spin write runs six iterations of the
// restoring dividers that wrap row and col to the side in use, then three
// row reads of the lattice memory, the neighbor count, the energy delta and
// the write-back, after which done is shown. Threshold, energy and moment
// loads and unknown commands go straight to the final state. A new
// command is accepted in the cycle done is shown. The lattice is held one
// row per memory word; each row has a valid bit that reset clears, so an
// unwritten row reads as all spins up and no clearing pass is needed after
// reset. Configuration writes are taken in any cycle (cfg_ready is always
// high) and must only come while the block is idle.
module ising_metropolis_flip #(
  parameter int SIDE_MAX = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [2:0]          cmd,
  input  logic [5:0]          row,
  input  logic [5:0]          col,
  input  logic [15:0]         random_u,
  input  logic signed [39:0]  value,
  output logic                done,
  output logic                flipped,
  output logic signed [39:0]  energy,
  output logic signed [13:0]  moment,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data
);

  localparam int AW = $clog2(SIDE_MAX);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DIV    = 3'd1;
  localparam logic [2:0] ST_RD_UP  = 3'd2;
  localparam logic [2:0] ST_RD_MID = 3'd3;
  localparam logic [2:0] ST_RD_DN  = 3'd4;
  localparam logic [2:0] ST_NSUM   = 3'd5;
  localparam logic [2:0] ST_CALC   = 3'd6;
  localparam logic [2:0] ST_FIN    = 3'd7;

  function automatic logic [6:0] mod_step(logic [6:0] rem, logic b, logic [6:0] d);
    logic [7:0] t;
    t = {rem, b};
    if (t >= {1'b0, d}) begin
      t = t - {1'b0, d};
    end
    return t[6:0];
  endfunction

  logic [2:0]          state;
  logic [2:0]          state_next;
  logic [2:0]          cnt;
  logic [6:0]          side;
  logic [6:0]          side_next;
  logic [6:0]          rem_r;
  logic [6:0]          rem_c;
  logic [2:0]          cmd_q;
  logic [5:0]          row_q;
  logic [5:0]          col_q;
  logic [15:0]         rnd_q;
  logic signed [39:0]  val_q;

  logic [6:0]          side_in_use;
  logic signed [15:0]  coupling_j;
  logic signed [15:0]  field_b;

  imf_pkg::thresh_t    thr [imf_pkg::NUM_THRESH];
  logic [SIDE_MAX-1:0] row_valid;

  logic [AW-1:0]       r_a;
  logic [AW-1:0]       c_a;
  logic [AW-1:0]       side_m1;
  logic [AW-1:0]       up_a;
  logic [AW-1:0]       dn_a;
  logic [AW-1:0]       lf_a;
  logic [AW-1:0]       rt_a;

  logic                ren;
  logic [AW-1:0]       raddr;
  logic [AW-1:0]       raddr_q;
  logic [SIDE_MAX-1:0] ram_rdata;
  logic [SIDE_MAX-1:0] row_rd;
  logic                wen;
  logic                wbit;
  logic [SIDE_MAX-1:0] wrow;

  logic [SIDE_MAX-1:0] mid_row;
  logic                up_bit;
  logic                lf_bit;
  logic                rt_bit;
  logic                s_bit;
  logic [2:0]          pos_cnt;

  logic signed [18:0]  j19;
  logic signed [18:0]  jn;
  logic signed [18:0]  h;
  logic signed [19:0]  d2;
  logic signed [19:0]  de_next;
  logic signed [19:0]  de;
  logic                take_next;
  logic                take;
  logic [3:0]          ti;
  logic signed [40:0]  esum;
  imf_pkg::energy_t    esat;
  imf_pkg::thresh_t    thr_clamp;

  logic                accept;

  assign accept    = start && !busy;
  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      side_in_use <= 7'd64;
      coupling_j  <= 16'sd256;
      field_b     <= 16'sd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        imf_pkg::CFG_SIDE: side_in_use <= cfg_data[6:0];
        imf_pkg::CFG_J:    coupling_j  <= cfg_data;
        imf_pkg::CFG_B:    field_b     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    side_next = side_in_use;
    if (side_in_use < 7'd2) begin
      side_next = 7'd2;
    end else if (int'(side_in_use) > SIDE_MAX) begin
      side_next = 7'(SIDE_MAX);
    end
  end

  // site and neighbor addresses
  assign r_a     = AW'(rem_r);
  assign c_a     = AW'(rem_c);
  assign side_m1 = AW'(side - 7'd1);
  assign up_a    = (r_a == '0) ? side_m1 : r_a - AW'(1);
  assign dn_a    = (r_a == side_m1) ? '0 : r_a + AW'(1);
  assign lf_a    = (c_a == '0) ? side_m1 : c_a - AW'(1);
  assign rt_a    = (c_a == side_m1) ? '0 : c_a + AW'(1);

  always_comb begin
    ren   = 1'b0;
    raddr = r_a;
    unique case (state)
      ST_RD_UP: begin
        ren   = 1'b1;
        raddr = up_a;
      end
      ST_RD_MID: begin
        ren   = 1'b1;
        raddr = r_a;
      end
      ST_RD_DN: begin
        ren   = 1'b1;
        raddr = dn_a;
      end
      default: ;
    endcase
  end

  // unwritten rows read as all spins up
  assign row_rd = row_valid[raddr_q] ? ram_rdata : '1;

  assign wen  = (state == ST_FIN) &&
                (((cmd_q == imf_pkg::CMD_STEP) && take) || (cmd_q == imf_pkg::CMD_WSPIN));
  assign wbit = (cmd_q == imf_pkg::CMD_STEP) ? !s_bit : val_q[0];

  always_comb begin
    wrow      = mid_row;
    wrow[c_a] = wbit;
  end

  imf_ram #(
    .WIDTH (SIDE_MAX),
    .DEPTH (SIDE_MAX)
  ) u_lattice (
    .clk   (clk),
    .wen   (wen),
    .waddr (r_a),
    .wdata (wrow),
    .ren   (ren),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  // energy delta and acceptance
  assign j19 = 19'(coupling_j);

  always_comb begin
    unique case (pos_cnt)
      3'd0:    jn = -(j19 <<< 2);
      3'd1:    jn = -(j19 <<< 1);
      3'd3:    jn = j19 <<< 1;
      3'd4:    jn = j19 <<< 2;
      default: jn = '0;
    endcase
  end

  assign h         = jn + 19'(field_b);
  assign d2        = 20'(h) <<< 1;
  assign de_next   = s_bit ? d2 : -d2;
  assign ti        = {pos_cnt, s_bit};
  assign take_next = de_next[19] || ({1'b0, rnd_q} < thr[ti]);

  assign esum = 41'(energy) + 41'(de);
  always_comb begin
    esat = esum[39:0];
    if (esum[40] != esum[39]) begin
      esat = esum[40] ? imf_pkg::E_MIN : imf_pkg::E_MAX;
    end
  end

  always_comb begin
    thr_clamp = val_q[16:0];
    if (val_q[39]) begin
      thr_clamp = '0;
    end else if (val_q > 40'sd65536) begin
      thr_clamp = imf_pkg::THR_ONE;
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ((cmd == imf_pkg::CMD_STEP) || (cmd == imf_pkg::CMD_WSPIN)) ?
                       ST_DIV : ST_FIN;
        end
      end
      ST_DIV: begin
        if (cnt == 3'd0) begin
          state_next = ST_RD_UP;
        end
      end
      ST_RD_UP:  state_next = ST_RD_MID;
      ST_RD_MID: state_next = ST_RD_DN;
      ST_RD_DN:  state_next = ST_NSUM;
      ST_NSUM:   state_next = ST_CALC;
      ST_CALC:   state_next = ST_FIN;
      ST_FIN:    state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      done    <= 1'b0;
      flipped <= 1'b0;
    end else begin
      state   <= state_next;
      done    <= (state == ST_FIN);
      flipped <= (state == ST_FIN) && (cmd_q == imf_pkg::CMD_STEP) && take;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= cmd;
      row_q <= row;
      col_q <= col;
      rnd_q <= random_u;
      val_q <= value;
      side  <= side_next;
      cnt   <= 3'd5;
      rem_r <= '0;
      rem_c <= '0;
    end
    if (state == ST_DIV) begin
      rem_r <= mod_step(rem_r, row_q[cnt], side);
      rem_c <= mod_step(rem_c, col_q[cnt], side);
      cnt   <= cnt - 3'd1;
    end
    raddr_q <= raddr;
    if (state == ST_RD_MID) begin
      up_bit <= row_rd[c_a];
    end
    if (state == ST_RD_DN) begin
      mid_row <= row_rd;
      lf_bit  <= row_rd[lf_a];
      rt_bit  <= row_rd[rt_a];
      s_bit   <= row_rd[c_a];
    end
    if (state == ST_NSUM) begin
      pos_cnt <= {2'b0, up_bit} + {2'b0, row_rd[c_a]} + {2'b0, lf_bit} + {2'b0, rt_bit};
    end
    if (state == ST_CALC) begin
      de   <= de_next;
      take <= take_next;
    end
  end

  // architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      energy    <= '0;
      moment    <= '0;
      row_valid <= '0;
      for (int i = 0; i < imf_pkg::NUM_THRESH; i++) begin
        thr[i] <= '0;
      end
    end else begin
      if (wen) begin
        row_valid[r_a] <= 1'b1;
      end
      if (state == ST_FIN) begin
        unique case (cmd_q)
          imf_pkg::CMD_STEP: begin
            if (take) begin
              energy <= esat;
              moment <= s_bit ? moment - 14'sd2 : moment + 14'sd2;
            end
          end
          imf_pkg::CMD_WTHR: begin
            if (row_q < 6'(imf_pkg::NUM_THRESH)) begin
              thr[row_q[3:0]] <= thr_clamp;
            end
          end
          imf_pkg::CMD_ELOAD: energy <= val_q;
          imf_pkg::CMD_MLOAD: moment <= val_q[13:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ----- hdl/imf_checker.sv -----
`include "ising_metropolis_flip_assert.svh"

module imf_checker (
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input logic                done,
  input logic                flipped,
  input imf_pkg::moment_t    moment
);

  // an accepted request leaves the block busy in the next cycle
  `IMF_ASSERT_NXT(a_accept_busy, start && !busy, busy)
  // busy only rises after an accepted request
  `IMF_ASSERT_IMP(a_busy_rise, $rose(busy), $past(start))
  // no result without a request in flight
  `IMF_ASSERT_NXT(a_no_spurious, !busy && !start, !done)
  // the result comes once the work is finished
  `IMF_ASSERT_IMP(a_done_idle, done, !busy && $past(busy))
  // a flip moves the moment by two
  `IMF_ASSERT_IMP(a_flip_moment, done && flipped,
                  (moment == $past(moment) + 14'sd2) || (moment == $past(moment) - 14'sd2))

endmodule

bind ising_metropolis_flip imf_checker u_imf_checker (.*);
